### src/ffv_pkg.sv
// ----------------------------------------------------------------------------
// ffv_pkg
// Shared widths, register indexes, selector codes and types for the
// motor feedforward voltage unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ffv_pkg;

    // Field widths
    localparam int ACTION_W       = 2;
    localparam int VEL_W          = 17;
    localparam int ACC_W          = 20;
    localparam int VOLT_W         = 15;
    localparam int SPEED_GAIN_W   = 16;
    localparam int BIAS_W         = 14;
    localparam int ACCEL_GAIN_W   = 16;
    localparam int LIMIT_W        = 14;

    // Configuration port
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    // Defaults for the top-level parameters
    localparam int BLEND_LOW_MMPS_DEF  = 0;
    localparam int BLEND_HIGH_MMPS_DEF = 120;
    localparam int FRAC_BITS_DEF       = 4;

    localparam logic [LIMIT_W-1:0] VOLTAGE_LIMIT_RST = 14'd6000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BIAS_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_BIAS_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_BIAS_LEFT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_BIAS_RIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT    = 3'd7;

    // Wheel selector codes; the spare code also averages both wheels
    localparam logic [ACTION_W-1:0] ACT_LEFT    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RIGHT   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_AVERAGE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;

    typedef struct packed {
        logic        [SPEED_GAIN_W-1:0] speed_gain_left;
        logic        [SPEED_GAIN_W-1:0] speed_gain_right;
        logic signed [BIAS_W-1:0]       start_bias_left;
        logic signed [BIAS_W-1:0]       start_bias_right;
        logic signed [BIAS_W-1:0]       run_bias_left;
        logic signed [BIAS_W-1:0]       run_bias_right;
        logic signed [ACCEL_GAIN_W-1:0] accel_gain;
        logic        [LIMIT_W-1:0]      voltage_limit;
    } ffv_cfg_t;

    typedef struct packed {
        logic signed [VOLT_W-1:0] voltage_mv;
        logic                     saturated;
    } ffv_result_t;

endpackage

`default_nettype wire

### src/ffv_cfg_regs.sv
// ----------------------------------------------------------------------------
// ffv_cfg_regs
// Configuration register file: decodes writes by index, holds gains,
// biases and the voltage limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ffv_cfg_regs import ffv_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output ffv_cfg_t                   cfg
);

    localparam ffv_cfg_t CFG_RST = '{
        speed_gain_left:  '0,
        speed_gain_right: '0,
        start_bias_left:  '0,
        start_bias_right: '0,
        run_bias_left:    '0,
        run_bias_right:   '0,
        accel_gain:       '0,
        voltage_limit:    VOLTAGE_LIMIT_RST
    };

    ffv_cfg_t cfg_reg;
    ffv_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_SPEED_GAIN_LEFT:  cfg_next.speed_gain_left  = cfg_wdata[SPEED_GAIN_W-1:0];
                REG_SPEED_GAIN_RIGHT: cfg_next.speed_gain_right = cfg_wdata[SPEED_GAIN_W-1:0];
                REG_START_BIAS_LEFT:  cfg_next.start_bias_left  = cfg_wdata[BIAS_W-1:0];
                REG_START_BIAS_RIGHT: cfg_next.start_bias_right = cfg_wdata[BIAS_W-1:0];
                REG_RUN_BIAS_LEFT:    cfg_next.run_bias_left    = cfg_wdata[BIAS_W-1:0];
                REG_RUN_BIAS_RIGHT:   cfg_next.run_bias_right   = cfg_wdata[BIAS_W-1:0];
                REG_ACCEL_GAIN:       cfg_next.accel_gain       = cfg_wdata[ACCEL_GAIN_W-1:0];
                REG_VOLTAGE_LIMIT:    cfg_next.voltage_limit    = cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/ffv_datapath.sv
// ----------------------------------------------------------------------------
// ffv_datapath
// Six-stage feedforward pipeline: decode/select, gain products, span
// scaling, signed sum, saturation check, reciprocal rounding divide.
// ----------------------------------------------------------------------------
`default_nettype none

module ffv_datapath import ffv_pkg::*; #(
    parameter int BLEND_LOW_MMPS  = BLEND_LOW_MMPS_DEF,
    parameter int BLEND_HIGH_MMPS = BLEND_HIGH_MMPS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [ACTION_W-1:0]        in_action,
    input  wire logic signed [VEL_W-1:0]    in_velocity,
    input  wire logic signed [ACC_W-1:0]    in_acceleration,
    input  wire ffv_cfg_t                   cfg,
    output logic                            out_valid,
    output ffv_result_t                     out_result
);

    // Common denominator q = 200 * scale * span; the rounding divide by 2q
    // is a shift by the power-of-two part and a multiply by the reciprocal of DIV_C.
    localparam longint SCALE  = longint'(1) << FRAC_BITS;
    localparam bit     BANDED = BLEND_HIGH_MMPS > BLEND_LOW_MMPS;
    localparam longint SPAN   = BANDED ?
                                longint'(BLEND_HIGH_MMPS - BLEND_LOW_MMPS) * SCALE : 1;
    localparam longint LO_RAW = longint'(BLEND_LOW_MMPS) * SCALE;
    localparam longint Q      = 200 * SCALE * SPAN;
    localparam int     SHIFT  = BANDED ? 4 + 2 * FRAC_BITS : 4 + FRAC_BITS;
    localparam longint DIV_C  = (2 * Q) >> SHIFT;
    localparam int     CB     = $clog2(DIV_C + 1);
    localparam int     YW     = LIMIT_W + CB;
    localparam int     K      = LIMIT_W + 2 * CB;
    localparam longint RECIP  = ((longint'(1) << K) + DIV_C - 1) / DIV_C;
    localparam int     RW     = $clog2(RECIP + 1);
    localparam int     PW     = YW + RW;

    localparam int SPAN_W = $clog2(SPAN + 1);
    localparam int NUM_W  = SPAN_W;
    localparam int S2_W   = BIAS_W + 1;
    localparam int DIFF_W = BIAS_W + 2;
    localparam int G2_W   = SPEED_GAIN_W + 1;
    localparam int VABS_W = VEL_W;
    localparam int AABS_W = ACC_W;
    localparam int PB_W   = DIFF_W + NUM_W + 1;
    localparam int PS_W   = G2_W + VABS_W;
    localparam int PA_W   = ACCEL_GAIN_W + ACC_W;
    localparam int BS_W   = S2_W + SPAN_W + 1;
    localparam int ST_W   = PS_W + SPAN_W;
    localparam int AT_W   = PA_W + SPAN_W + 2;
    localparam int N_W    = PA_W + SPAN_W + 4;
    localparam int Q_W    = $clog2(Q + 1);
    localparam int LQ_W   = LIMIT_W + Q_W;
    localparam int CMP_W  = (N_W > LQ_W) ? N_W : LQ_W;
    localparam int XW     = N_W + 2;

    localparam logic signed [BS_W-1:0] BS_SPAN  = BS_W'(SPAN);
    localparam logic signed [AT_W-1:0] AT_MUL   = AT_W'(2 * SPAN);
    localparam logic signed [N_W-1:0]  BIAS_MUL = N_W'(100 * SCALE);

    // ---------------- stage 1: direction, wheel select, blend fraction
    logic                     dir_v, dir_a;
    logic [VABS_W-1:0]        vabs_c;
    logic [AABS_W-1:0]        aabs_c;
    logic signed [VEL_W:0]    vneg_c;
    logic signed [ACC_W:0]    aneg_c;
    logic        [SPEED_GAIN_W-1:0] g_a, g_b;
    logic signed [BIAS_W-1:0] sb_a, sb_b, rb_a, rb_b;
    logic signed [S2_W-1:0]   s2_next, r2_c;
    logic signed [DIFF_W-1:0] diff_next;
    logic [G2_W-1:0]          g2_next;
    logic [NUM_W-1:0]         num_next;
    logic                     zero1_next, neg1_next;

    always_comb begin
        vneg_c = -(VEL_W + 1)'(in_velocity);
        aneg_c = -(ACC_W + 1)'(in_acceleration);
        vabs_c = in_velocity[VEL_W-1] ? vneg_c[VEL_W-1:0] : in_velocity[VEL_W-1:0];
        aabs_c = in_acceleration[ACC_W-1] ? aneg_c[ACC_W-1:0] : in_acceleration[ACC_W-1:0];
        dir_v  = longint'(vabs_c) >= SCALE;
        dir_a  = longint'(aabs_c) >= SCALE;
        zero1_next = !dir_v && !dir_a;
        neg1_next  = dir_v ? in_velocity[VEL_W-1] : in_acceleration[ACC_W-1];

        // doubled values: each wheel counts twice, average adds both once
        case (in_action)
            ACT_LEFT: begin
                g_a = cfg.speed_gain_left;  g_b = cfg.speed_gain_left;
                sb_a = cfg.start_bias_left; sb_b = cfg.start_bias_left;
                rb_a = cfg.run_bias_left;   rb_b = cfg.run_bias_left;
            end
            ACT_RIGHT: begin
                g_a = cfg.speed_gain_right;  g_b = cfg.speed_gain_right;
                sb_a = cfg.start_bias_right; sb_b = cfg.start_bias_right;
                rb_a = cfg.run_bias_right;   rb_b = cfg.run_bias_right;
            end
            default: begin
                g_a = cfg.speed_gain_left;  g_b = cfg.speed_gain_right;
                sb_a = cfg.start_bias_left; sb_b = cfg.start_bias_right;
                rb_a = cfg.run_bias_left;   rb_b = cfg.run_bias_right;
            end
        endcase
        g2_next   = G2_W'(g_a) + G2_W'(g_b);
        s2_next   = S2_W'(sb_a) + S2_W'(sb_b);
        r2_c      = S2_W'(rb_a) + S2_W'(rb_b);
        diff_next = DIFF_W'(r2_c) - DIFF_W'(s2_next);

        if (BANDED) begin
            if (longint'(vabs_c) <= LO_RAW) begin
                num_next = '0;
            end else if (longint'(vabs_c) - LO_RAW >= SPAN) begin
                num_next = NUM_W'(SPAN);
            end else begin
                num_next = NUM_W'(longint'(vabs_c) - LO_RAW);
            end
        end else begin
            num_next = (longint'(vabs_c) >= LO_RAW) ? NUM_W'(1) : '0;
        end
    end

    logic                     v1_reg, zero1_reg, neg1_reg;
    logic [VABS_W-1:0]        vabs1_reg;
    logic signed [ACC_W-1:0]  acc1_reg;
    logic signed [S2_W-1:0]   s2_1_reg;
    logic signed [DIFF_W-1:0] diff1_reg;
    logic [G2_W-1:0]          g2_1_reg;
    logic [NUM_W-1:0]         num1_reg;

    // ---------------- stage 2: gain products
    logic signed [PB_W-1:0] pb2_next;
    logic [PS_W-1:0]        ps2_next;
    logic signed [PA_W-1:0] pa2_next;

    always_comb begin
        pb2_next = PB_W'(diff1_reg) * PB_W'($signed({1'b0, num1_reg}));
        ps2_next = PS_W'(g2_1_reg) * PS_W'(vabs1_reg);
        pa2_next = PA_W'(cfg.accel_gain) * PA_W'(acc1_reg);
    end

    logic                   v2_reg, zero2_reg, neg2_reg;
    logic signed [S2_W-1:0] s2_2_reg;
    logic signed [PB_W-1:0] pb2_reg;
    logic [PS_W-1:0]        ps2_reg;
    logic signed [PA_W-1:0] pa2_reg;

    // ---------------- stage 3: bring every term onto the span denominator
    logic signed [BS_W-1:0] bs3_next;
    logic [ST_W-1:0]        st3_next;
    logic signed [AT_W-1:0] at3_next;

    always_comb begin
        bs3_next = BS_W'(s2_2_reg) * BS_SPAN + BS_W'(pb2_reg);
        st3_next = ST_W'(ps2_reg) * ST_W'(SPAN);
        at3_next = AT_W'(pa2_reg) * AT_MUL;
    end

    logic                   v3_reg, zero3_reg, neg3_reg;
    logic signed [BS_W-1:0] bs3_reg;
    logic [ST_W-1:0]        st3_reg;
    logic signed [AT_W-1:0] at3_reg;

    // ---------------- stage 4: signed numerator
    logic signed [N_W-1:0] mag_sum_c;
    logic signed [N_W-1:0] n4_next;

    always_comb begin
        mag_sum_c = N_W'(bs3_reg) * BIAS_MUL + $signed(N_W'(st3_reg));
        n4_next   = (neg3_reg ? -mag_sum_c : mag_sum_c) + N_W'(at3_reg);
    end

    logic                  v4_reg, zero4_reg;
    logic signed [N_W-1:0] n4_reg;

    // ---------------- stage 5: magnitude, limit check, pre-shift
    logic [N_W-1:0]  mag_c;
    logic [XW-1:0]   x_c;
    logic [YW-1:0]   y5_next;
    logic            sat5_next;
    logic [LQ_W-1:0] limit_q_reg;

    always_comb begin
        mag_c     = n4_reg[N_W-1] ? N_W'(-n4_reg) : N_W'(n4_reg);
        sat5_next = CMP_W'(mag_c) > CMP_W'(limit_q_reg);
        x_c       = XW'({mag_c, 1'b0}) + XW'(Q);
        y5_next   = YW'(x_c >> SHIFT);
    end

    logic            v5_reg, zero5_reg, neg5_reg, sat5_reg;
    logic [YW-1:0]   y5_reg;

    // ---------------- stage 6: reciprocal multiply
    logic [PW-1:0] prod6_next;
    assign prod6_next = PW'(y5_reg) * PW'(RECIP);

    logic          v6_reg, zero6_reg, neg6_reg, sat6_reg;
    logic [PW-1:0] prod6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        limit_q_reg <= LQ_W'(cfg.voltage_limit) * LQ_W'(Q);
        if (en) begin
            zero1_reg <= zero1_next;
            neg1_reg  <= neg1_next;
            vabs1_reg <= vabs_c;
            acc1_reg  <= in_acceleration;
            s2_1_reg  <= s2_next;
            diff1_reg <= diff_next;
            g2_1_reg  <= g2_next;
            num1_reg  <= num_next;

            zero2_reg <= zero1_reg;
            neg2_reg  <= neg1_reg;
            s2_2_reg  <= s2_1_reg;
            pb2_reg   <= pb2_next;
            ps2_reg   <= ps2_next;
            pa2_reg   <= pa2_next;

            zero3_reg <= zero2_reg;
            neg3_reg  <= neg2_reg;
            bs3_reg   <= bs3_next;
            st3_reg   <= st3_next;
            at3_reg   <= at3_next;

            zero4_reg <= zero3_reg;
            n4_reg    <= n4_next;

            zero5_reg <= zero4_reg;
            neg5_reg  <= n4_reg[N_W-1];
            sat5_reg  <= sat5_next;
            y5_reg    <= y5_next;

            zero6_reg <= zero5_reg;
            neg6_reg  <= neg5_reg;
            sat6_reg  <= sat5_reg;
            prod6_reg <= prod6_next;
        end
    end

    // ---------------- result select
    logic [LIMIT_W-1:0] res_c;

    always_comb begin
        res_c = sat6_reg ? cfg.voltage_limit : prod6_reg[K +: LIMIT_W];
        if (zero6_reg) begin
            out_result.voltage_mv = '0;
        end else if (neg6_reg) begin
            out_result.voltage_mv = -VOLT_W'(res_c);
        end else begin
            out_result.voltage_mv = VOLT_W'(res_c);
        end
        out_result.saturated = sat6_reg && !zero6_reg;
    end

    assign out_valid = v6_reg;

endmodule

`default_nettype wire

### src/ffv_out_stage.sv
// ----------------------------------------------------------------------------
// ffv_out_stage
// Output register plus one skid entry; the pipeline stalls only when
// the skid entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module ffv_out_stage import ffv_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire ffv_result_t in_result,
    output logic       pipe_en,
    output logic       m_valid,
    input  wire logic  m_ready,
    output ffv_result_t m_result
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ffv_result_t out_reg, out_next;
    ffv_result_t skid_reg, skid_next;
    logic        push, out_fire;

    assign pipe_en  = !skid_valid_reg;
    assign push     = pipe_en && in_valid;
    assign out_fire = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || out_fire) begin
                out_next       = in_result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = in_result;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

`default_nettype wire

### src/motor_feedforward_voltage_unit.sv
// ----------------------------------------------------------------------------
// motor_feedforward_voltage_unit
// Feedforward motor command in mV from target velocity and acceleration,
// with start/run bias blend, rounding and clamping to the voltage limit.
// ----------------------------------------------------------------------------
//
//  Port group   Direction  Handshake          Carries
//  s_*          in         s_valid / s_ready  action, velocity, acceleration
//  m_*          out        m_valid / m_ready  voltage_mv, saturated
//  cfg_*        in         cfg_we             register index and write data
//
//  One item per cycle while s_ready is high; each accepted item passes the
//  six pipeline stages and then the output register before m_valid.
//  The output register has one skid entry behind it; s_ready drops only
//  when that entry is full, and all stages hold together while it is.
//  Synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedforward_voltage_unit import ffv_pkg::*; #(
    parameter int BLEND_LOW_MMPS  = BLEND_LOW_MMPS_DEF,
    parameter int BLEND_HIGH_MMPS = BLEND_HIGH_MMPS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [ACTION_W-1:0]      s_action,
    input  wire logic signed [VEL_W-1:0]  s_velocity,
    input  wire logic signed [ACC_W-1:0]  s_acceleration,

    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [VOLT_W-1:0]      m_voltage_mv,
    output logic                          m_saturated,

    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

    ffv_cfg_t    cfg;
    ffv_result_t pipe_result;
    ffv_result_t out_result;
    logic        pipe_valid;
    logic        pipe_en;

    ffv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ffv_datapath #(
        .BLEND_LOW_MMPS  (BLEND_LOW_MMPS),
        .BLEND_HIGH_MMPS (BLEND_HIGH_MMPS),
        .FRAC_BITS       (FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (pipe_en),
        .in_valid        (s_valid),
        .in_action       (s_action),
        .in_velocity     (s_velocity),
        .in_acceleration (s_acceleration),
        .cfg             (cfg),
        .out_valid       (pipe_valid),
        .out_result      (pipe_result)
    );

    ffv_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pipe_valid),
        .in_result (pipe_result),
        .pipe_en   (pipe_en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (out_result)
    );

    assign s_ready      = pipe_en;
    assign m_voltage_mv = out_result.voltage_mv;
    assign m_saturated  = out_result.saturated;

    // skid entry is only ever filled behind a held output item
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid occupied while output register empty");

    // a full skid entry stays full until the output item is taken
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready && !(m_valid && m_ready)) |=> !s_ready)
        else $error("skid entry dropped without output transfer");

    // the pipeline restarts only after an output transfer
    a_restart_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> $past(m_valid && m_ready))
        else $error("pipeline restarted without output transfer");

endmodule

`default_nettype wire

### bench/motor_feedforward_voltage_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedforward_voltage_unit_test
// Self-checking bench for the feedforward voltage unit. A driver feeds velocity
// and acceleration items from a queue, with random gaps on both handshakes. An
// in-bench predictor computes each command exactly and the monitor compares the
// results in order. Runs cover the reset defaults, a typical setting, both
// register extremes and random settings.
// ----------------------------------------------------------------------------

module motor_feedforward_voltage_unit_test;
    import ffv_pkg::*;

    localparam int     BLEND_LO  = BLEND_LOW_MMPS_DEF;
    localparam int     BLEND_HI  = BLEND_HIGH_MMPS_DEF;
    localparam int     FRAC      = FRAC_BITS_DEF;
    localparam longint SCALE     = longint'(1) << FRAC;
    localparam int     LATENCY   = 7;

    typedef struct {
        logic        [ACTION_W-1:0] action;
        logic signed [VEL_W-1:0]    velocity;
        logic signed [ACC_W-1:0]    acceleration;
    } ffv_cmd_t;

    logic                         aclk;
    logic                         aresetn        = 1'b0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic        [ACTION_W-1:0]   s_action       = '0;
    logic signed [VEL_W-1:0]      s_velocity     = '0;
    logic signed [ACC_W-1:0]      s_acceleration = '0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic signed [VOLT_W-1:0]     m_voltage_mv;
    logic                         m_saturated;
    logic                         cfg_we         = 1'b0;
    logic        [CFG_IDX_W-1:0]  cfg_addr       = '0;
    logic        [CFG_DATA_W-1:0] cfg_wdata      = '0;

    ffv_cmd_t    pending_cmds[$];
    ffv_result_t expected_volts[$];
    ffv_cmd_t    cur_cmd;
    ffv_result_t want;
    ffv_cfg_t    gains_cfg;
    int unsigned stall_pct   = 33;
    int          error_count = 0;

    motor_feedforward_voltage_unit #(
        .BLEND_LOW_MMPS  (BLEND_LO),
        .BLEND_HIGH_MMPS (BLEND_HI),
        .FRAC_BITS       (FRAC)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_velocity     (s_velocity),
        .s_acceleration (s_acceleration),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_voltage_mv   (m_voltage_mv),
        .m_saturated    (m_saturated),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Exact command: all terms over one denominator, one rounding at the end.
    function automatic ffv_result_t predict_voltage(ffv_cmd_t cmd);
        longint      vel, acc, vabs, aabs, dir;
        longint      sl, sr, rl, rr, gl, gr, s2, r2, g2, ka, lim;
        longint      span, frac, q, n, mag, res, signed_res;
        ffv_result_t r;
        r    = '0;
        vel  = $signed(cmd.velocity);
        acc  = $signed(cmd.acceleration);
        vabs = (vel < 0) ? -vel : vel;
        aabs = (acc < 0) ? -acc : acc;
        if (vabs >= SCALE) begin
            dir = (vel < 0) ? -1 : 1;
        end else if (aabs >= SCALE) begin
            dir = (acc < 0) ? -1 : 1;
        end else begin
            return r;
        end
        sl  = $signed(gains_cfg.start_bias_left);
        sr  = $signed(gains_cfg.start_bias_right);
        rl  = $signed(gains_cfg.run_bias_left);
        rr  = $signed(gains_cfg.run_bias_right);
        gl  = gains_cfg.speed_gain_left;
        gr  = gains_cfg.speed_gain_right;
        ka  = $signed(gains_cfg.accel_gain);
        lim = gains_cfg.voltage_limit;
        // doubled values keep the average exact
        case (cmd.action)
            ACT_LEFT: begin
                s2 = 2 * sl;
                r2 = 2 * rl;
                g2 = 2 * gl;
            end
            ACT_RIGHT: begin
                s2 = 2 * sr;
                r2 = 2 * rr;
                g2 = 2 * gr;
            end
            default: begin
                s2 = sl + sr;
                r2 = rl + rr;
                g2 = gl + gr;
            end
        endcase
        if (BLEND_HI > BLEND_LO) begin
            span = longint'(BLEND_HI - BLEND_LO) * SCALE;
            frac = vabs - longint'(BLEND_LO) * SCALE;
            if (frac < 0) frac = 0;
            if (frac > span) frac = span;
        end else begin
            span = 1;
            frac = (vabs >= longint'(BLEND_LO) * SCALE) ? 1 : 0;
        end
        q = 200 * SCALE * span;
        n = dir * ((s2 * span + (r2 - s2) * frac) * 100 * SCALE + g2 * vabs * span)
            + ka * acc * 2 * span;
        mag = (n < 0) ? -n : n;
        if (mag > lim * q) begin
            r.saturated = 1'b1;
            res = lim;
        end else begin
            res = (2 * mag + q) / (2 * q);
        end
        signed_res = (n < 0) ? -res : res;
        r.voltage_mv = signed_res[VOLT_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_volts.push_back(predict_voltage(cur_cmd));
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= stall_pct) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_action       <= cur_cmd.action;
                    s_velocity     <= cur_cmd.velocity;
                    s_acceleration <= cur_cmd.acceleration;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_volts.size() == 0) begin
                error_count++;
                $display("%0t: unexpected item, expected none, actual %0d sat %0b",
                         $time, m_voltage_mv, m_saturated);
            end else begin
                want = expected_volts.pop_front();
                if (m_voltage_mv !== want.voltage_mv) begin
                    error_count++;
                    $display("%0t: voltage_mv mismatch, expected %0d, actual %0d",
                             $time, want.voltage_mv, m_voltage_mv);
                end
                if (m_saturated !== want.saturated) begin
                    error_count++;
                    $display("%0t: saturated mismatch, expected %0b, actual %0b",
                             $time, want.saturated, m_saturated);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic queue_cmd(input int act, input int vel, input int acc);
        ffv_cmd_t cmd;
        cmd.action       = act[ACTION_W-1:0];
        cmd.velocity     = vel[VEL_W-1:0];
        cmd.acceleration = acc[ACC_W-1:0];
        pending_cmds.push_back(cmd);
    endtask

    // checked between edges so the driver's updates have settled
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_valid || expected_volts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SPEED_GAIN_LEFT:  gains_cfg.speed_gain_left  = data;
            REG_SPEED_GAIN_RIGHT: gains_cfg.speed_gain_right = data;
            REG_START_BIAS_LEFT:  gains_cfg.start_bias_left  = data[BIAS_W-1:0];
            REG_START_BIAS_RIGHT: gains_cfg.start_bias_right = data[BIAS_W-1:0];
            REG_RUN_BIAS_LEFT:    gains_cfg.run_bias_left    = data[BIAS_W-1:0];
            REG_RUN_BIAS_RIGHT:   gains_cfg.run_bias_right   = data[BIAS_W-1:0];
            REG_ACCEL_GAIN:       gains_cfg.accel_gain       = data;
            REG_VOLTAGE_LIMIT:    gains_cfg.voltage_limit    = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Biases go out sign-extended to the port width.
    task automatic load_config(input int kv_l, input int kv_r, input int st_l,
                               input int st_r, input int rn_l, input int rn_r,
                               input int ka, input int lim);
        write_reg(REG_SPEED_GAIN_LEFT,  kv_l[CFG_DATA_W-1:0]);
        write_reg(REG_SPEED_GAIN_RIGHT, kv_r[CFG_DATA_W-1:0]);
        write_reg(REG_START_BIAS_LEFT,  st_l[CFG_DATA_W-1:0]);
        write_reg(REG_START_BIAS_RIGHT, st_r[CFG_DATA_W-1:0]);
        write_reg(REG_RUN_BIAS_LEFT,    rn_l[CFG_DATA_W-1:0]);
        write_reg(REG_RUN_BIAS_RIGHT,   rn_r[CFG_DATA_W-1:0]);
        write_reg(REG_ACCEL_GAIN,       ka[CFG_DATA_W-1:0]);
        write_reg(REG_VOLTAGE_LIMIT,    lim[CFG_DATA_W-1:0]);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_random_config();
        load_config(int'($urandom_range(65535)), int'($urandom_range(65535)),
                    int'($urandom_range(16382)) - 8191, int'($urandom_range(16382)) - 8191,
                    int'($urandom_range(16382)) - 8191, int'($urandom_range(16382)) - 8191,
                    int'($urandom_range(65535)) - 32768, int'($urandom_range(16383)));
    endtask

    // Mix of sub-unit, blend-band, moderate and full-range values.
    task automatic run_random(input int count);
        int vel, acc;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0:       vel = int'($urandom_range(63)) - 32;
                1:       vel = int'($urandom_range(4800)) - 2400;
                2:       vel = int'($urandom_range(32000)) - 16000;
                default: vel = int'($urandom);
            endcase
            case ($urandom_range(3))
                0:       acc = int'($urandom_range(63)) - 32;
                1:       acc = int'($urandom_range(8000)) - 4000;
                2:       acc = 0;
                default: acc = int'($urandom);
            endcase
            queue_cmd(int'($urandom_range(3)), vel, acc);
        end
        wait_idle();
    endtask

    initial begin
        gains_cfg = '0;
        gains_cfg.voltage_limit = VOLTAGE_LIMIT_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults
        queue_cmd(ACT_LEFT, 1600, 1600);
        queue_cmd(ACT_RIGHT, -65536, 524287);
        queue_cmd(ACT_AVERAGE, 0, 0);
        wait_idle();

        load_config(350, 420, 600, -450, 250, 300, 45, 6000);
        queue_cmd(ACT_LEFT, 0, 0);             // no direction
        queue_cmd(ACT_LEFT, 15, 15);           // both just under one unit
        queue_cmd(ACT_LEFT, -15, 16);          // direction from acceleration
        queue_cmd(ACT_RIGHT, 15, -16);
        queue_cmd(ACT_RIGHT, 16, 0);           // smallest velocity with direction
        queue_cmd(ACT_AVERAGE, -16, -524288);
        queue_cmd(ACT_SPARE, 1919, 0);         // blend band edges
        queue_cmd(ACT_LEFT, 1920, 0);
        queue_cmd(ACT_RIGHT, -1921, 100);
        queue_cmd(ACT_AVERAGE, 65535, 524287);
        queue_cmd(ACT_SPARE, -65536, -524288);
        queue_cmd(ACT_LEFT, -65536, 524287);
        queue_cmd(ACT_RIGHT, 65535, -524288);
        queue_cmd(ACT_AVERAGE, 960, -3000);
        queue_cmd(ACT_LEFT, 0, -524288);
        queue_cmd(ACT_RIGHT, 0, 524287);
        queue_cmd(ACT_SPARE, -1, -1);
        wait_idle();
        run_random(80);

        load_config(65535, 65535, 8191, -8191, -8191, 8191, 32767, 16383);
        run_random(70);

        load_config(0, 0, -8191, -8191, -8191, -8191, -32768, 0);
        run_random(50);

        // long stretch without gaps on either side
        stall_pct = 0;
        load_random_config();
        run_random(100);

        stall_pct = 33;
        load_random_config();
        run_random(80);

        repeat (2 * LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
